[rtl/core/uart_rf_pkg.sv]
// ----------------------------------------------------------------------------
// uart_rf_pkg
// Shared constants, codes and transaction types for the UART register block.
// ----------------------------------------------------------------------------
package uart_rf_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RX    = 2'd2;

    localparam logic [4:0] REG_ID0    = 5'h00;
    localparam logic [4:0] REG_ID1    = 5'h04;
    localparam logic [4:0] REG_ID2    = 5'h08;
    localparam logic [4:0] REG_ID3    = 5'h0c;
    localparam logic [4:0] REG_DATA   = 5'h10;
    localparam logic [4:0] REG_STATUS = 5'h14;
    localparam logic [4:0] REG_BAUDL  = 5'h18;
    localparam logic [4:0] REG_BAUDH  = 5'h1c;

    localparam int ST_TXEMPTY = 7;
    localparam int ST_TX_IE   = 6;
    localparam int ST_RXEMPTY = 5;
    localparam int ST_ROOM1   = 4;
    localparam int ST_RXFULL  = 3;
    localparam int ST_RX_IE   = 2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [4:0] addr;
        logic [7:0] wdata;
        logic [7:0] rx_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] rdata;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       irq;
        logic       bus_error;
        logic       rx_dropped;
        logic       rx_ready;
    } t_out;

endpackage

[rtl/core/uart_registers_with_rx_fifo_top.sv]
// Results: a transaction's result is held in stage 1 from acceptance, then
//   moves to the output register once that register is empty or being taken.
// Throughput: 1 transaction per cycle when not stalled; the FIFO memory port takes
//   one read and one write per cycle, its read data registered in the next stage.
// Two result stages sit between the sides, so input is taken while a result waits.
// Reset: synchronous, active low; clears FIFO pointers, enables, baud divisor.
// ----------------------------------------------------------------------------
// uart_registers_with_rx_fifo_top
// Byte-wide UART register file with a receive FIFO held in a synchronous
// memory. State is updated at acceptance; FIFO read data joins the next stage.
// ----------------------------------------------------------------------------
module uart_registers_with_rx_fifo_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  uart_rf_pkg::t_in  i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output uart_rf_pkg::t_out o_res
);
    import uart_rf_pkg::*;

    logic [7:0]       r_fifo_mem [FIFO_DEPTH];
    logic [7:0]       r_mem_q;

    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_rx_ie, n_rx_ie;
    logic             r_tx_ie, n_tx_ie;
    logic [15:0]      r_baud, n_baud;

    logic             r_s1_v;
    t_out             r_s1, n_s1;
    logic             r_s1_pop, n_pop;
    logic             r_out_v;
    t_out             r_out;

    logic             accept;
    logic             s1_move;
    logic             mem_we;
    logic             mem_re;
    logic             fifo_full;
    logic [PTR_W-1:0] head_inc;
    logic [CNT_W:0]   slot_sum;
    logic [PTR_W-1:0] slot;
    logic [7:0]       status;

    assign s1_move = r_s1_v && (!r_out_v || i_ready);
    assign o_ready = !r_s1_v || s1_move;
    assign accept  = i_valid && o_ready;

    assign fifo_full = (r_count == CNT_W'(FIFO_DEPTH));
    assign head_inc  = (r_head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_head + PTR_W'(1);

    always_comb begin
        slot_sum = (CNT_W+1)'(r_head) + (CNT_W+1)'(r_count);
        if (slot_sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
            slot_sum = slot_sum - (CNT_W+1)'(FIFO_DEPTH);
        end
        slot = slot_sum[PTR_W-1:0];
    end

    always_comb begin
        status             = '0;
        status[ST_TXEMPTY] = 1'b1;
        status[ST_TX_IE]   = r_tx_ie;
        status[ST_RXEMPTY] = (r_count == '0);
        status[ST_ROOM1]   = (r_count == CNT_W'(FIFO_DEPTH - 1));
        status[ST_RXFULL]  = fifo_full;
        status[ST_RX_IE]   = r_rx_ie;
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        n_rx_ie = r_rx_ie;
        n_tx_ie = r_tx_ie;
        n_baud  = r_baud;
        n_s1    = '0;
        n_pop   = 1'b0;
        mem_we  = 1'b0;
        mem_re  = 1'b0;
        case (i_item.cmd)
            CMD_READ: begin
                unique case (i_item.addr) inside
                    REG_ID0, REG_ID1, REG_ID2, REG_ID3: begin
                    end
                    REG_DATA: begin
                        if (r_count != '0) begin
                            n_pop   = 1'b1;
                            mem_re  = accept;
                            n_head  = head_inc;
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    REG_STATUS: n_s1.rdata = status;
                    REG_BAUDL:  n_s1.rdata = r_baud[7:0];
                    REG_BAUDH:  n_s1.rdata = r_baud[15:8];
                    default:    n_s1.bus_error = 1'b1;
                endcase
            end
            CMD_WRITE: begin
                unique case (i_item.addr) inside
                    REG_ID0, REG_ID1, REG_ID2, REG_ID3: begin
                    end
                    REG_DATA: begin
                        n_s1.tx_valid = 1'b1;
                        n_s1.tx_byte  = i_item.wdata;
                    end
                    REG_STATUS: begin
                        n_tx_ie = i_item.wdata[ST_TX_IE];
                        n_rx_ie = i_item.wdata[ST_RX_IE];
                    end
                    REG_BAUDL: n_baud = {r_baud[15:8], i_item.wdata};
                    REG_BAUDH: n_baud = {i_item.wdata, r_baud[7:0]};
                    default:   n_s1.bus_error = 1'b1;
                endcase
            end
            CMD_RX: begin
                if (fifo_full) begin
                    n_s1.rx_dropped = 1'b1;
                end else begin
                    mem_we  = accept;
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        n_s1.irq      = (n_rx_ie && (n_count != '0)) || n_tx_ie;
        n_s1.rx_ready = (n_count != CNT_W'(FIFO_DEPTH));
    end

    // FIFO memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_fifo_mem[slot] <= i_item.rx_byte;
        end
        if (mem_re) begin
            r_mem_q <= r_fifo_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rx_ie <= 1'b0;
            r_tx_ie <= 1'b0;
            r_baud  <= '0;
        end else if (accept) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rx_ie <= n_rx_ie;
            r_tx_ie <= n_tx_ie;
            r_baud  <= n_baud;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (accept) begin
            r_s1_v <= 1'b1;
        end else if (s1_move) begin
            r_s1_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1     <= n_s1;
            r_s1_pop <= n_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (s1_move) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out       <= r_s1;
            r_out.rdata <= r_s1_pop ? r_mem_q : r_s1.rdata;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("FIFO count beyond depth");

    a_drop_keeps_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.cmd == CMD_RX && fifo_full) |=> fifo_full)
        else $error("dropped byte changed FIFO count");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_pop) |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not decrement count");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && !s1_move) |=> (r_s1_v && $stable(r_s1)))
        else $error("stalled stage lost its transaction");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> !(r_out.tx_valid && (r_out.bus_error || r_out.rx_dropped)))
        else $error("conflicting result flags");

endmodule
